// File: hdl/tlvd_pkg.sv
// Shared types and constants for the TLV frame deframer.
// No dependencies; imported by the deframer core.
`default_nettype none

package tlvd_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] MIN_LENGTH  = 8'd4;

    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FTYPE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DEV   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TYPE  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TLEN  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_VALUE = 3'd6;

    localparam logic [3:0] KIND_DISCARD  = 4'd0;
    localparam logic [3:0] KIND_HEADER   = 4'd1;
    localparam logic [3:0] KIND_LENGTH   = 4'd2;
    localparam logic [3:0] KIND_FTYPE    = 4'd3;
    localparam logic [3:0] KIND_DEVICE   = 4'd4;
    localparam logic [3:0] KIND_TLV_TYPE = 4'd5;
    localparam logic [3:0] KIND_TLV_LEN  = 4'd6;
    localparam logic [3:0] KIND_TLV_VAL  = 4'd7;
    localparam logic [3:0] KIND_CHECKSUM = 4'd8;

    localparam logic [2:0] ST_BUSY       = 3'd0;
    localparam logic [2:0] ST_OK         = 3'd1;
    localparam logic [2:0] ST_HEADER_ERR = 3'd2;
    localparam logic [2:0] ST_LENGTH_ERR = 3'd3;
    localparam logic [2:0] ST_CSUM_ERR   = 3'd4;
    localparam logic [2:0] ST_MALFORMED  = 3'd5;

    typedef struct packed {
        logic [3:0] byte_kind;
        logic [7:0] byte_value;
        logic [7:0] tlv_number;
        logic [7:0] value_offset;
        logic [2:0] status;
        logic       frame_end;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/tlv_frame_deframer_core.sv
// Byte-serial TLV frame deframer: labels each received byte and gives the frame verdict.
// Depends on tlvd_pkg for phase, kind and status codes and the result word type.
// Takes one byte per clock while o_in_stall is low. Each result is registered into the
// result register as its byte is accepted, or into a one-word skid buffer behind it if
// the output is stalled; the buffer lets the input take one more byte after the output
// stalls. o_in_stall is that buffer's occupancy. The per-byte phase update and running
// checksum are combinational, which sets the rate at one byte per clock.
`default_nettype none

module tlv_frame_deframer_core
    import tlvd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_byte_kind,
    output logic [7:0]      o_byte_value,
    output logic [7:0]      o_tlv_number,
    output logic [7:0]      o_value_offset,
    output logic [2:0]      o_status,
    output logic            o_frame_end
);

    logic [7:0]         r_query_code;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [7:0]         r_frame_length, n_frame_length;
    logic [7:0]         r_byte_position, n_byte_position;
    logic [7:0]         r_running_sum, n_running_sum;
    logic [7:0]         r_value_left, n_value_left;
    logic [7:0]         r_tlv_counter, n_tlv_counter;
    logic               r_is_query, n_is_query;
    logic               r_overrun_seen, n_overrun_seen;
    logic [7:0]         r_value_index, n_value_index;

    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;
    logic    in_accept, out_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid & ~r_skid_valid;
    assign out_fire    = r_out_valid & ~i_out_stall;

    always_comb begin
        logic [7:0] sum_b;
        logic [7:0] room;
        logic [7:0] left_dec;
        sum_b    = r_running_sum + i_rx_byte;
        room     = r_frame_length - 8'd1 - r_byte_position;
        left_dec = r_value_left - 8'd1;

        n_phase         = r_phase;
        n_frame_length  = r_frame_length;
        n_byte_position = r_byte_position;
        n_running_sum   = r_running_sum;
        n_value_left    = r_value_left;
        n_tlv_counter   = r_tlv_counter;
        n_is_query      = r_is_query;
        n_overrun_seen  = r_overrun_seen;
        n_value_index   = r_value_index;

        n_result.byte_kind    = KIND_DISCARD;
        n_result.byte_value   = i_rx_byte;
        n_result.tlv_number   = 8'd0;
        n_result.value_offset = 8'd0;
        n_result.status       = ST_BUSY;
        n_result.frame_end    = 1'b0;

        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == HEADER_BYTE) begin
                    n_result.byte_kind = KIND_HEADER;
                    n_running_sum      = i_rx_byte;
                    n_byte_position    = 8'd1;
                    n_value_left       = 8'd0;
                    n_value_index      = 8'd0;
                    n_tlv_counter      = 8'd0;
                    n_overrun_seen     = 1'b0;
                    n_is_query         = 1'b0;
                    n_phase            = PH_LEN;
                end else begin
                    n_result.status = ST_HEADER_ERR;
                end
            end
            PH_LEN: begin
                n_result.byte_kind = KIND_LENGTH;
                if (i_rx_byte < MIN_LENGTH) begin
                    n_result.status    = ST_LENGTH_ERR;
                    n_result.frame_end = 1'b1;
                    n_phase            = PH_HUNT;
                end else begin
                    n_frame_length  = i_rx_byte;
                    n_running_sum   = sum_b;
                    n_byte_position = 8'd2;
                    n_phase         = PH_FTYPE;
                end
            end
            PH_FTYPE: begin
                n_result.byte_kind = KIND_FTYPE;
                n_is_query         = (i_rx_byte == r_query_code);
                n_running_sum      = sum_b;
                n_byte_position    = 8'd3;
                n_phase            = PH_DEV;
            end
            PH_DEV: begin
                n_result.byte_kind = KIND_DEVICE;
                n_running_sum      = sum_b;
                n_byte_position    = 8'd4;
                n_phase            = PH_TYPE;
            end
            default: begin
                if (r_byte_position >= r_frame_length) begin
                    n_result.byte_kind  = KIND_CHECKSUM;
                    n_result.tlv_number = r_tlv_counter;
                    n_result.frame_end  = 1'b1;
                    if (i_rx_byte != r_running_sum) begin
                        n_result.status = ST_CSUM_ERR;
                    end else if (r_overrun_seen) begin
                        n_result.status = ST_MALFORMED;
                    end else begin
                        n_result.status = ST_OK;
                    end
                    n_phase = PH_HUNT;
                end else begin
                    if (r_phase == PH_TYPE) begin
                        n_result.byte_kind  = KIND_TLV_TYPE;
                        n_result.tlv_number = r_tlv_counter;
                        n_tlv_counter       = r_tlv_counter + 8'd1;
                        if (!r_is_query) begin
                            if (r_byte_position + 8'd1 == r_frame_length) begin
                                n_overrun_seen = 1'b1;
                            end
                            n_phase = PH_TLEN;
                        end
                    end else if (r_phase == PH_TLEN) begin
                        n_result.byte_kind  = KIND_TLV_LEN;
                        n_result.tlv_number = r_tlv_counter - 8'd1;
                        if (i_rx_byte > room) begin
                            n_overrun_seen = 1'b1;
                        end
                        n_value_left  = i_rx_byte;
                        n_value_index = 8'd0;
                        n_phase       = (i_rx_byte != 8'd0) ? PH_VALUE : PH_TYPE;
                    end else begin
                        n_result.byte_kind    = KIND_TLV_VAL;
                        n_result.tlv_number   = r_tlv_counter - 8'd1;
                        n_result.value_offset = r_value_index;
                        n_value_index         = r_value_index + 8'd1;
                        n_value_left          = left_dec;
                        if (left_dec == 8'd0) begin
                            n_phase = PH_TYPE;
                        end
                    end
                    n_running_sum   = sum_b;
                    n_byte_position = r_byte_position + 8'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_code    <= 8'd0;
            r_phase         <= PH_HUNT;
            r_frame_length  <= 8'd0;
            r_byte_position <= 8'd0;
            r_running_sum   <= 8'd0;
            r_value_left    <= 8'd0;
            r_tlv_counter   <= 8'd0;
            r_is_query      <= 1'b0;
            r_overrun_seen  <= 1'b0;
            r_value_index   <= 8'd0;
        end else begin
            if (i_cfg_valid) begin
                r_query_code <= i_cfg_data;
            end
            if (in_accept) begin
                r_phase         <= n_phase;
                r_frame_length  <= n_frame_length;
                r_byte_position <= n_byte_position;
                r_running_sum   <= n_running_sum;
                r_value_left    <= n_value_left;
                r_tlv_counter   <= n_tlv_counter;
                r_is_query      <= n_is_query;
                r_overrun_seen  <= n_overrun_seen;
                r_value_index   <= n_value_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_kind    = r_out.byte_kind;
    assign o_byte_value   = r_out.byte_value;
    assign o_tlv_number   = r_out.tlv_number;
    assign o_value_offset = r_out.value_offset;
    assign o_status       = r_out.status;
    assign o_frame_end    = r_out.frame_end;

endmodule

`default_nettype wire
